FILE: hw/rtl/dtu_pkg.sv
package dtu_pkg;

  localparam int MAX_COLS = 1024;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int LEN_W = 11;
  localparam int DIST_W = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;
  localparam int EPOCH_W = 24;
  localparam int DIV_W = 26;
  localparam int DVS_W = 9;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUM  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_DEN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 4'd3;

  localparam logic [1:0] DIV_C1A = 2'd0;
  localparam logic [1:0] DIV_C1B = 2'd1;
  localparam logic [1:0] DIV_C2A = 2'd2;
  localparam logic [1:0] DIV_C2B = 2'd3;

  // Per column: the last value written in each of the three most recent rows
  // that wrote the column, with the row numbers of the two newest.
  typedef struct packed {
    logic [EPOCH_W-1:0] e1;
    logic [EPOCH_W-1:0] e0;
    logic [DIST_W-1:0]  v2;
    logic [DIST_W-1:0]  v1;
    logic [DIST_W-1:0]  v0;
  } hist_t;

  typedef struct packed {
    logic       clr;
    logic       accept;
    logic       rd_first;
    logic       rd_next;
    logic       cap_cur;
    logic       cap_nxt;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_take;
    logic       finish;
  } dtu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_col_zero;
    logic fg;
    logic div_done;
    logic out_full;
  } dtu_stat_t;

  function automatic hist_t hist_write(hist_t h, logic [EPOCH_W-1:0] e,
                                       logic [DIST_W-1:0] v);
    hist_t h2;
    h2 = h;
    if (h.e0 == e) begin
      h2.v0 = v;
    end else begin
      h2.v2 = h.v1;
      h2.v1 = h.v0;
      h2.v0 = v;
      h2.e1 = h.e0;
      h2.e0 = e;
    end
    return h2;
  endfunction

  function automatic logic [DIST_W-1:0] above_one(hist_t h, logic [EPOCH_W-1:0] e);
    return (h.e0 == e) ? h.v1 : h.v0;
  endfunction

  function automatic logic [DIST_W-1:0] above_two(hist_t h, logic [EPOCH_W-1:0] e);
    logic [EPOCH_W-1:0] em1;
    em1 = e - EPOCH_W'(1);
    if (h.e0 == e) begin
      return (h.e1 == em1) ? h.v2 : h.v1;
    end else if (h.e0 == em1) begin
      return h.v1;
    end else begin
      return h.v0;
    end
  endfunction

endpackage

FILE: hw/rtl/dtu_line_mem.sv
module dtu_line_mem
  import dtu_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  hist_t            wdata,
  input  logic [COL_W-1:0] raddr,
  output hist_t            rdata
);

  hist_t mem [MAX_COLS];
  hist_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/dtu_div.sv
module dtu_div
  import dtu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W:0]       t1;
  logic [DVS_W:0]       t2;
  logic                 ge1;
  logic                 ge2;
  logic [DVS_W-1:0]     r1;
  logic [DVS_W-1:0]     rem_nxt;
  logic [DIV_W-1:0]     qa;
  logic [DIV_W-1:0]     quo_nxt;
  logic                 last_step;

  assign last_step = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    t1      = {rem_r, quo_r[DIV_W-1]};
    ge1     = (t1 >= {1'b0, dvs_r});
    r1      = ge1 ? DVS_W'(t1 - {1'b0, dvs_r}) : t1[DVS_W-1:0];
    qa      = {quo_r[DIV_W-2:0], ge1};
    t2      = {r1, qa[DIV_W-1]};
    ge2     = (t2 >= {1'b0, dvs_r});
    rem_nxt = ge2 ? DVS_W'(t2 - {1'b0, dvs_r}) : t2[DVS_W-1:0];
    quo_nxt = {qa[DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: hw/rtl/dtu_datapath.sv
module dtu_datapath
  import dtu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtu_cmd_t              cmd,
  output dtu_stat_t             stat,
  input  logic                  in_pixel,
  input  logic                  in_frame,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [DIST_W-1:0]     out_dist,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]         num_r;
  logic [8:0]         den_r;
  logic [DIST_W-1:0]  lim_r;
  logic [LEN_W-1:0]   len_r;

  logic [COL_W-1:0]   col_r;
  logic [1:0]         rows_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [COL_W-1:0]   clr_cnt_r;
  logic               fg_r;

  hist_t              ent_cur_r;
  hist_t              ent_nxt_r;
  logic [DIST_W-1:0]  a1p_r, a1z_r, a1m1_r, a1m2_r;
  logic [DIST_W-1:0]  a2p_r, a2z_r, a2m1_r, a2m2_r;
  logic [DIST_W-1:0]  cm1_r, cm2_r;
  logic [16:0]        f1_r, f2_r;
  logic [DIV_W-1:0]   c1_r, c2_r;

  logic               out_valid_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_last_r;

  logic [7:0]         p0;
  logic [7:0]         p_eff;
  logic [8:0]         q_eff;
  logic [8:0]         r_eff;
  logic [DIST_W-1:0]  lim_eff;
  logic [LEN_W-1:0]   len_eff;

  logic               r1ok, r2ok, nxt_in, is_last;
  logic               in_z, in_m1, in_m2;
  logic [DIST_W-1:0]  a_val, b_val, c_min, tb1, tb2, tb3, tb4;
  logic [16:0]        c_inc;
  logic [DIST_W-1:0]  t1, t2, dt;

  logic [16:0]        mop_a;
  logic [8:0]         mop_b;
  logic [DIV_W-1:0]   madd, prod, dvd;
  logic [DVS_W-1:0]   dvs;
  logic               div_done;
  logic [DIV_W-1:0]   quot;

  logic               mem_we;
  logic [COL_W-1:0]   mem_waddr, mem_raddr;
  hist_t              mem_wdata, mem_rdata;
  logic [COL_W-1:0]   col_nxt;

  always_comb begin
    p0      = (num_r == 8'd0) ? 8'd1 : num_r;
    q_eff   = (den_r < 9'd2) ? 9'd2 : den_r;
    p_eff   = ({1'b0, p0} >= q_eff) ? 8'(q_eff - 9'd1) : p0;
    r_eff   = q_eff - {1'b0, p_eff};
    lim_eff = (lim_r == '0) ? DIST_MAX : lim_r;
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_COLS)) begin
      len_eff = LEN_W'(MAX_COLS);
    end else begin
      len_eff = len_r;
    end
  end

  // Columns at or beyond the row length read as zero, which matters when the
  // row length is lowered in the middle of a row.
  always_comb begin
    r1ok    = (rows_r != 2'd0);
    r2ok    = rows_r[1];
    nxt_in  = (({1'b0, col_r} + LEN_W'(1)) < len_eff);
    in_z    = ({1'b0, col_r} < len_eff);
    in_m1   = ({1'b0, col_r} <= len_eff);
    in_m2   = ({1'b0, col_r} < (len_eff + LEN_W'(2)));
    is_last = !nxt_in;
    a_val   = (r1ok && nxt_in) ? a1p_r : '0;
    tb1     = (r1ok && in_m2) ? a1m2_r : '0;
    tb2     = (r2ok && in_m1) ? a2m1_r : '0;
    tb3     = (r2ok && in_m2) ? a2m2_r : '0;
    tb4     = in_m1 ? cm1_r : '0;
    b_val   = in_m2 ? cm2_r : '0;
    b_val   = (tb4 < b_val) ? tb4 : b_val;
    b_val   = (tb1 < b_val) ? tb1 : b_val;
    b_val   = (tb2 < b_val) ? tb2 : b_val;
    b_val   = (tb3 < b_val) ? tb3 : b_val;
    c_min   = (r1ok && in_z) ? a1z_r : '0;
    tb4     = (r1ok && in_m1) ? a1m1_r : '0;
    c_min   = (tb4 < c_min) ? tb4 : c_min;
    tb4     = (r2ok && in_z) ? a2z_r : '0;
    c_min   = (tb4 < c_min) ? tb4 : c_min;
    c_inc   = {1'b0, c_min} + 17'd1;
    t1      = (c1_r < DIV_W'(lim_eff)) ? c1_r[DIST_W-1:0] : lim_eff;
    t2      = (c2_r < DIV_W'(t1)) ? c2_r[DIST_W-1:0] : t1;
    if (!fg_r) begin
      dt = '0;
    end else begin
      dt = (c_inc < 17'(t2)) ? c_inc[DIST_W-1:0] : t2;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_C1A: begin
        mop_a = {1'b0, a_val};
        mop_b = r_eff;
        madd  = DIV_W'(q_eff) - DIV_W'(1);
        dvs   = q_eff;
      end
      DIV_C1B: begin
        mop_a = f1_r;
        mop_b = q_eff;
        madd  = DIV_W'(r_eff);
        dvs   = r_eff;
      end
      DIV_C2A: begin
        mop_a = {1'b0, b_val};
        mop_b = {1'b0, p_eff};
        madd  = '0;
        dvs   = q_eff;
      end
      default: begin
        mop_a = f2_r + 17'd1;
        mop_b = q_eff;
        madd  = DIV_W'(p_eff) - DIV_W'(1);
        dvs   = {1'b0, p_eff};
      end
    endcase
    prod = {9'd0, mop_a} * {17'd0, mop_b};
    dvd  = prod + madd;
  end

  dtu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    mem_we    = cmd.clr || cmd.finish;
    mem_waddr = cmd.clr ? clr_cnt_r : col_r;
    mem_wdata = cmd.clr ? hist_t'('0) : hist_write(ent_cur_r, epoch_r, dt);
    mem_raddr = cmd.rd_first ? COL_W'(0) : COL_W'(col_r + COL_W'(1));
    col_nxt   = in_frame ? COL_W'(0) : col_r;
  end

  dtu_line_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= 8'd1;
      den_r       <= 9'd2;
      lim_r       <= '0;
      len_r       <= LEN_W'(MAX_COLS);
      col_r       <= '0;
      rows_r      <= '0;
      epoch_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RATIO_NUM:  num_r <= cfg_wdata[7:0];
          REG_RATIO_DEN:  den_r <= cfg_wdata[8:0];
          REG_DIST_LIMIT: lim_r <= cfg_wdata[DIST_W-1:0];
          REG_ROW_LENGTH: len_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + COL_W'(1);
      end
      if (cmd.accept) begin
        col_r <= col_nxt;
        if (in_frame) begin
          rows_r <= '0;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        if (is_last) begin
          col_r   <= '0;
          epoch_r <= epoch_r + EPOCH_W'(1);
          if (!rows_r[1]) begin
            rows_r <= rows_r + 2'd1;
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fg_r <= in_pixel;
      if (col_nxt == '0) begin
        cm1_r  <= '0;
        cm2_r  <= '0;
        a1m1_r <= '0;
        a1m2_r <= '0;
        a2m1_r <= '0;
        a2m2_r <= '0;
      end else begin
        a1m2_r    <= a1m1_r;
        a1m1_r    <= a1z_r;
        a1z_r     <= a1p_r;
        a2m2_r    <= a2m1_r;
        a2m1_r    <= a2z_r;
        a2z_r     <= a2p_r;
        ent_cur_r <= ent_nxt_r;
      end
    end
    if (cmd.cap_cur) begin
      ent_cur_r <= mem_rdata;
      a1z_r     <= above_one(mem_rdata, epoch_r);
      a2z_r     <= above_two(mem_rdata, epoch_r);
    end
    if (cmd.cap_nxt) begin
      ent_nxt_r <= mem_rdata;
      a1p_r     <= above_one(mem_rdata, epoch_r);
      a2p_r     <= above_two(mem_rdata, epoch_r);
    end
    if (cmd.div_take) begin
      case (cmd.div_sel)
        DIV_C1A: f1_r <= quot[16:0];
        DIV_C1B: c1_r <= quot;
        DIV_C2A: f2_r <= quot[16:0];
        default: c2_r <= quot;
      endcase
    end
    if (cmd.finish) begin
      out_dist_r <= dt;
      out_last_r <= is_last;
      cm2_r      <= cm1_r;
      cm1_r      <= dt;
    end
  end

  always_comb begin
    stat.clr_last       = (clr_cnt_r == COL_W'(MAX_COLS - 1));
    stat.start_col_zero = (col_nxt == '0);
    stat.fg             = fg_r;
    stat.div_done       = div_done;
    stat.out_full       = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_dist  = out_dist_r;
  assign out_last  = out_last_r;

endmodule

FILE: hw/rtl/dtu_ctrl.sv
module dtu_ctrl
  import dtu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dtu_stat_t stat,
  output dtu_cmd_t  cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD0C = 4'd3;
  localparam logic [3:0] S_RDN  = 4'd4;
  localparam logic [3:0] S_CAP  = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_D1   = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_D2   = 4'd9;
  localparam logic [3:0] S_M3   = 4'd10;
  localparam logic [3:0] S_D3   = 4'd11;
  localparam logic [3:0] S_M4   = 4'd12;
  localparam logic [3:0] S_D4   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.start_col_zero ? S_RD0 : S_RDN;
        end
      end
      S_RD0: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_RD0C;
      end
      S_RD0C: begin
        cmd.cap_cur = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = S_CAP;
      end
      S_RDN: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cmd.cap_nxt = 1'b1;
        state_nxt   = stat.fg ? S_M1 : S_FIN;
      end
      S_M1: begin
        cmd.div_sel   = DIV_C1A;
        cmd.div_start = 1'b1;
        state_nxt     = S_D1;
      end
      S_D1: begin
        cmd.div_sel = DIV_C1A;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_M2;
        end
      end
      S_M2: begin
        cmd.div_sel   = DIV_C1B;
        cmd.div_start = 1'b1;
        state_nxt     = S_D2;
      end
      S_D2: begin
        cmd.div_sel = DIV_C1B;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_M3;
        end
      end
      S_M3: begin
        cmd.div_sel   = DIV_C2A;
        cmd.div_start = 1'b1;
        state_nxt     = S_D3;
      end
      S_D3: begin
        cmd.div_sel = DIV_C2A;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_M4;
        end
      end
      S_M4: begin
        cmd.div_sel   = DIV_C2B;
        cmd.div_start = 1'b1;
        state_nxt     = S_D4;
      end
      S_D4: begin
        cmd.div_sel = DIV_C2B;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/ratio_ns_distance_transform_unit.sv
// Channel   Direction  Handshake              Content
// in_       slave      in_tvalid/in_tready    one binary pixel, frame start in tuser
// out_      master     out_tvalid/out_tready  one distance, row end in tlast
// cfg_      slave      cfg_valid/cfg_ready    register index and write data
//
// A background pixel goes through the read and capture states to the finish state,
// with one more read state at the first column of a row. A foreground pixel
// also runs four divisions in turn on one shared two-bit-per-cycle divider.
// After reset a clearing pass sweeps all 1024 line memory entries; no item
// is accepted during it. The result register holds until taken, and the next
// item is accepted while it waits.
module ratio_ns_distance_transform_unit
  import dtu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] pixel_set
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] distance
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dtu_cmd_t  cmd;
  dtu_stat_t stat;

  assign cfg_ready = 1'b1;

  dtu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_pixel  (in_tdata[0]),
    .in_frame  (in_tuser),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_dist  (out_tdata),
    .out_last  (out_tlast),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data)
  );

endmodule

FILE: hw/rtl/dtu_checker.sv
module dtu_checker
  import dtu_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [15:0]           out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is at work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind ratio_ns_distance_transform_unit dtu_checker u_dtu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: dv/dtu_checker.sv
`timescale 1ns / 100ps

module dtu_scoreboard
  import dtu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  typedef struct packed {
    logic [15:0] distance;
    logic        row_last;
  } dist_result_t;

  logic [7:0]  num_reg;
  logic [8:0]  den_reg;
  logic [15:0] limit_reg;
  logic [10:0] len_reg;
  logic [15:0] row_one [MAX_COLS];
  logic [15:0] row_two [MAX_COLS];
  logic [15:0] row_cur [MAX_COLS];
  int unsigned col_next;
  int unsigned rows_done;
  dist_result_t expected_q[$];

  function automatic int unsigned read_px(int unsigned dy, int unsigned col, int dx,
                                          int unsigned len);
    int c;
    c = int'(col) + dx;
    if (c < 0 || c >= int'(len) || c >= MAX_COLS) return 0;
    if (dy == 0) return row_cur[c];
    if (dy > rows_done) return 0;
    return (dy == 1) ? row_one[c] : row_two[c];
  endfunction

  function automatic int unsigned min2(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  task automatic predict_pixel(logic fg, logic fs);
    longint unsigned p, q, r, f, t, lim;
    int unsigned len, col, dt, a, b, c;
    dist_result_t res;
    q = (den_reg < 2) ? 2 : den_reg;
    p = (num_reg == 0) ? 1 : num_reg;
    if (p >= q) p = q - 1;
    lim = (limit_reg == 0) ? 65535 : limit_reg;
    len = (len_reg == 0) ? 1 : len_reg;
    if (len > MAX_COLS) len = MAX_COLS;
    if (fs) begin
      col_next = 0;
      rows_done = 0;
    end
    col = (col_next >= MAX_COLS) ? MAX_COLS - 1 : col_next;
    dt = 0;
    if (fg) begin
      r = q - p;
      a = read_px(1, col, 1, len);
      f = (a * r + q - 1) / q;
      t = (f * q + r) / r;
      dt = int'((t < lim) ? t : lim);
      b = read_px(0, col, -1, len);
      b = min2(b, read_px(0, col, -2, len));
      b = min2(b, read_px(1, col, -2, len));
      b = min2(b, read_px(2, col, -1, len));
      b = min2(b, read_px(2, col, -2, len));
      f = (b * p) / q;
      t = ((f + 1) * q + p - 1) / p;
      if (t < dt) dt = int'(t);
      c = read_px(1, col, 0, len);
      c = min2(c, read_px(1, col, -1, len));
      c = min2(c, read_px(2, col, 0, len));
      dt = min2(dt, c + 1);
    end
    row_cur[col] = dt[15:0];
    res.distance = dt[15:0];
    res.row_last = (col + 1 >= len);
    if (res.row_last) begin
      row_two = row_one;
      row_one = row_cur;
      col_next = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      col_next = col + 1;
    end
    expected_q.push_back(res);
  endtask

  always @(posedge clk) begin
    dist_result_t exp_res;
    int errs;
    errs = 0;
    if (!rst_n) begin
      num_reg <= 8'd1;
      den_reg <= 9'd2;
      limit_reg <= 16'd0;
      len_reg <= 11'd1024;
      for (int i = 0; i < MAX_COLS; i++) begin
        row_one[i] = '0;
        row_two[i] = '0;
        row_cur[i] = '0;
      end
      col_next = 0;
      rows_done = 0;
      fail_count <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RATIO_NUM: num_reg <= cfg_data[7:0];
          REG_RATIO_DEN: den_reg <= cfg_data[8:0];
          REG_DIST_LIMIT: limit_reg <= cfg_data;
          REG_ROW_LENGTH: len_reg <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("Unexpected result: distance %0d row_last %0b", out_tdata, out_tlast);
          errs++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_tdata !== exp_res.distance) begin
            $error("distance: expected %0d, actual %0d", exp_res.distance, out_tdata);
            errs++;
          end
          if (out_tlast !== exp_res.row_last) begin
            $error("row_last: expected %0b, actual %0b", exp_res.row_last, out_tlast);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
      if (in_tvalid && in_tready) predict_pixel(in_tdata[0], in_tuser);
    end
  end

  assign pending = expected_q.size();

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import dtu_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    results_seen;
  int                    pixels_sent = 0;
  int                    hold_cycles = 0;
  bit                    no_gaps = 1'b0;

  always #5 clk = ~clk;

  ratio_ns_distance_transform_unit DUT (.*);

  dtu_scoreboard checker_i (.*);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_pixel(logic fg, logic fs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(19);
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, fg};
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    pixels_sent++;
  endtask

  task automatic send_frame(int rows, int cols, int density, bit noise);
    for (int i = 0; i < rows * cols; i++) begin
      send_pixel(($urandom_range(99) < density), (i == 0) || (noise && $urandom_range(30) == 0));
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(19) < 14);
    end
  end

  initial begin
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_RATIO_NUM, 16'd1);
    write_reg(REG_RATIO_DEN, 16'd2);
    write_reg(REG_DIST_LIMIT, 16'd0);
    write_reg(REG_ROW_LENGTH, 16'd6);
    // Directed: an all-foreground frame, lone pixels, and a fresh frame start.
    for (int i = 0; i < 18; i++) send_pixel(1'b1, i == 0);
    send_pixel(1'b0, 1'b1);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
    drain();
    // Out-of-range settings are clamped by the block.
    write_reg(REG_RATIO_NUM, 16'd0);
    write_reg(REG_RATIO_DEN, 16'd0);
    write_reg(REG_DIST_LIMIT, 16'd2);
    write_reg(REG_ROW_LENGTH, 16'd0);
    for (int i = 0; i < 4; i++) send_pixel(1'b1, i == 0);
    drain();
    write_reg(REG_RATIO_NUM, 16'd255);
    write_reg(REG_RATIO_DEN, 16'hFFFF);
    write_reg(REG_DIST_LIMIT, 16'hFFFF);
    write_reg(REG_ROW_LENGTH, 16'hFFFF);
    send_frame(1, 30, 90, 1'b0);
    drain();
    write_reg(REG_ROW_LENGTH, 16'd1024);
    no_gaps = 1'b1;
    send_frame(1, 40, 95, 1'b0);
    no_gaps = 1'b0;
    drain();
    // Receiver holds off while pixels keep arriving.
    write_reg(REG_ROW_LENGTH, 16'd5);
    fork
      hold_cycles = 400;
      send_frame(3, 5, 50, 1'b0);
    join
    drain();
    while (pixels_sent < 900) begin
      write_reg(REG_RATIO_DEN, 16'($urandom_range(256, 2)));
      write_reg(REG_RATIO_NUM, 16'($urandom_range(255, 0)));
      write_reg(REG_DIST_LIMIT, ($urandom_range(3) == 0) ? 16'($urandom_range(8))
                                : 16'($urandom));
      len = ($urandom_range(15) == 0) ? $urandom_range(1024, 700) : $urandom_range(12, 1);
      write_reg(REG_ROW_LENGTH, 16'(len));
      no_gaps = ($urandom_range(4) == 0);
      if (len > 100) begin
        send_frame(1, len / 8, 80, 1'b0);
      end else begin
        send_frame($urandom_range(6, 1), len, $urandom_range(100, 30), $urandom_range(3) == 0);
      end
      if ($urandom_range(3) == 0) begin
        drain();
        write_reg(REG_ROW_LENGTH, 16'($urandom_range(12, 1)));
        send_frame(1, 3, 70, 1'b0);
      end
      no_gaps = 1'b0;
      drain();
    end
    drain();
    $display("Covered %0d pixels and %0d results over many ratio, limit and row settings.",
             pixels_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
